// ===== design/hapd_pkg.sv =====
// Shared types, codes, decode function and last-digit function of the hex ASCII packet deframer.
package hapd_pkg;

    localparam int CNT_W = 4;
    localparam int PH_W  = 4;
    localparam int ST_W  = 4;
    localparam int IDX_W = 3;

    localparam int DEF_SEQUENCE_DIGITS    = 4;
    localparam int DEF_COMMAND_DIGITS     = 2;
    localparam int DEF_FIRST_DATA_DIGITS  = 8;
    localparam int DEF_SECOND_DATA_DIGITS = 4;
    localparam int DEF_CHECKSUM_DIGITS    = 4;

    localparam logic [7:0] UPPER_OFFSET = 8'h37;
    localparam logic [7:0] DIGIT_OFFSET = 8'h30;
    localparam logic [7:0] NIBBLE_MAX   = 8'h0F;

    localparam logic [PH_W-1:0] PH_WAIT = 4'd0;
    localparam logic [PH_W-1:0] PH_SEQ  = 4'd1;
    localparam logic [PH_W-1:0] PH_SEP1 = 4'd2;
    localparam logic [PH_W-1:0] PH_CMD  = 4'd3;
    localparam logic [PH_W-1:0] PH_SEP2 = 4'd4;
    localparam logic [PH_W-1:0] PH_D1   = 4'd5;
    localparam logic [PH_W-1:0] PH_D2   = 4'd6;
    localparam logic [PH_W-1:0] PH_SEP3 = 4'd7;
    localparam logic [PH_W-1:0] PH_CHK  = 4'd8;
    localparam logic [PH_W-1:0] PH_END  = 4'd9;

    localparam logic [ST_W-1:0] ST_NONE     = 4'd0;
    localparam logic [ST_W-1:0] ST_OK       = 4'd1;
    localparam logic [ST_W-1:0] ST_BAD_SEQ  = 4'd2;
    localparam logic [ST_W-1:0] ST_NO_SEP1  = 4'd3;
    localparam logic [ST_W-1:0] ST_BAD_CMD  = 4'd4;
    localparam logic [ST_W-1:0] ST_NO_SEP2  = 4'd5;
    localparam logic [ST_W-1:0] ST_BAD_D1   = 4'd6;
    localparam logic [ST_W-1:0] ST_BAD_D2   = 4'd7;
    localparam logic [ST_W-1:0] ST_NO_SEP3  = 4'd8;
    localparam logic [ST_W-1:0] ST_BAD_CHK  = 4'd9;
    localparam logic [ST_W-1:0] ST_NO_END   = 4'd10;

    localparam logic [IDX_W-1:0] REG_START_BYTE = 3'd0;
    localparam logic [IDX_W-1:0] REG_FIRST_SEP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_SECOND_SEP = 3'd2;
    localparam logic [IDX_W-1:0] REG_THIRD_SEP  = 3'd3;
    localparam logic [IDX_W-1:0] REG_END_BYTE   = 3'd4;

    localparam logic [7:0] RST_START_BYTE = 8'h02;
    localparam logic [7:0] RST_SEPARATOR  = 8'h3A;
    localparam logic [7:0] RST_END_BYTE   = 8'h03;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] first_separator;
        logic [7:0] second_separator;
        logic [7:0] third_separator;
        logic [7:0] end_byte;
    } t_cfg;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            packet_done;
        logic [15:0]     sequence_value;
        logic [7:0]      command_value;
        logic [31:0]     first_data_value;
        logic [15:0]     second_data_value;
        logic [15:0]     checksum_value;
    } t_result;

    function automatic logic [7:0] decode_byte(input logic [7:0] b);
        logic [7:0] d;
        d = b;
        if (b inside {[8'h41:8'h46]}) begin
            d = b - UPPER_OFFSET;
        end else if (b inside {[8'h30:8'h39]}) begin
            d = b - DIGIT_OFFSET;
        end
        return d;
    endfunction

    function automatic logic last_digit(input logic [CNT_W-1:0] cnt,
                                        input logic [CNT_W:0] ndigits);
        return ({1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1}) == ndigits;
    endfunction

endpackage

// ===== design/hapd_cfg_regs.sv =====
// Configuration registers of the deframer: framing byte values.
module hapd_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [hapd_pkg::IDX_W-1:0] i_index,
    input  logic [7:0]                i_data,
    output hapd_pkg::t_cfg            o_cfg
);
    import hapd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte       <= RST_START_BYTE;
            r_cfg.first_separator  <= RST_SEPARATOR;
            r_cfg.second_separator <= RST_SEPARATOR;
            r_cfg.third_separator  <= RST_SEPARATOR;
            r_cfg.end_byte         <= RST_END_BYTE;
        end else if (i_we) begin
            case (i_index)
                REG_START_BYTE: r_cfg.start_byte       <= i_data;
                REG_FIRST_SEP:  r_cfg.first_separator  <= i_data;
                REG_SECOND_SEP: r_cfg.second_separator <= i_data;
                REG_THIRD_SEP:  r_cfg.third_separator  <= i_data;
                REG_END_BYTE:   r_cfg.end_byte         <= i_data;
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/hapd_parser.sv =====
// Packet phase tracker and field accumulators, one byte per request.
module hapd_parser #(
    parameter int SEQUENCE_DIGITS    = hapd_pkg::DEF_SEQUENCE_DIGITS,
    parameter int COMMAND_DIGITS     = hapd_pkg::DEF_COMMAND_DIGITS,
    parameter int FIRST_DATA_DIGITS  = hapd_pkg::DEF_FIRST_DATA_DIGITS,
    parameter int SECOND_DATA_DIGITS = hapd_pkg::DEF_SECOND_DATA_DIGITS,
    parameter int CHECKSUM_DIGITS    = hapd_pkg::DEF_CHECKSUM_DIGITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_rx_byte,
    input  hapd_pkg::t_cfg      i_cfg,
    output hapd_pkg::t_result   o_result
);
    import hapd_pkg::*;

    localparam logic [CNT_W:0] SEQ_N = (CNT_W+1)'(SEQUENCE_DIGITS);
    localparam logic [CNT_W:0] CMD_N = (CNT_W+1)'(COMMAND_DIGITS);
    localparam logic [CNT_W:0] D1_N  = (CNT_W+1)'(FIRST_DATA_DIGITS);
    localparam logic [CNT_W:0] D2_N  = (CNT_W+1)'(SECOND_DATA_DIGITS);
    localparam logic [CNT_W:0] CHK_N = (CNT_W+1)'(CHECKSUM_DIGITS);

    logic [PH_W-1:0]  r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_seq, n_seq;
    logic [7:0]       r_cmd, n_cmd;
    logic [31:0]      r_d1, n_d1;
    logic [15:0]      r_d2, n_d2;
    logic [15:0]      r_chk, n_chk;

    logic [7:0]       dec;
    logic [3:0]       nib;
    logic             is_digit;
    logic [CNT_W-1:0] cnt_inc;
    t_result          res;

    assign dec      = decode_byte(i_rx_byte);
    assign nib      = dec[3:0];
    assign is_digit = (dec <= NIBBLE_MAX);
    assign cnt_inc  = r_count + {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_seq   = r_seq;
        n_cmd   = r_cmd;
        n_d1    = r_d1;
        n_d2    = r_d2;
        n_chk   = r_chk;
        res     = '0;
        if (dec == i_cfg.start_byte) begin
            n_phase = PH_SEQ;
            n_count = '0;
            n_seq   = '0;
            n_cmd   = '0;
            n_d1    = '0;
            n_d2    = '0;
            n_chk   = '0;
        end else begin
            case (r_phase)
                PH_WAIT: n_phase = PH_WAIT;
                PH_SEQ: begin
                    if (!is_digit) begin
                        res.status = ST_BAD_SEQ;
                        n_phase    = PH_WAIT;
                    end else begin
                        n_seq = {r_seq[11:0], nib};
                        if (last_digit(r_count, SEQ_N)) begin
                            n_count = '0;
                            n_phase = PH_SEP1;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
                PH_SEP1: begin
                    if (dec == i_cfg.first_separator) begin
                        n_count = '0;
                        n_phase = PH_CMD;
                    end else begin
                        res.status = ST_NO_SEP1;
                        n_phase    = PH_WAIT;
                    end
                end
                PH_CMD: begin
                    if (!is_digit) begin
                        res.status = ST_BAD_CMD;
                        n_phase    = PH_WAIT;
                    end else begin
                        n_cmd = {r_cmd[3:0], nib};
                        if (last_digit(r_count, CMD_N)) begin
                            n_count = '0;
                            n_phase = PH_SEP2;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
                PH_SEP2: begin
                    if (dec == i_cfg.second_separator) begin
                        n_count = '0;
                        n_phase = PH_D1;
                    end else begin
                        res.status = ST_NO_SEP2;
                        n_phase    = PH_WAIT;
                    end
                end
                PH_D1: begin
                    if (!is_digit) begin
                        res.status = ST_BAD_D1;
                        n_phase    = PH_WAIT;
                    end else begin
                        n_d1 = {r_d1[27:0], nib};
                        if (last_digit(r_count, D1_N)) begin
                            n_count = '0;
                            n_phase = PH_D2;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
                PH_D2: begin
                    if (!is_digit) begin
                        res.status = ST_BAD_D2;
                        n_phase    = PH_WAIT;
                    end else begin
                        n_d2 = {r_d2[11:0], nib};
                        if (last_digit(r_count, D2_N)) begin
                            n_count = '0;
                            n_phase = PH_SEP3;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
                PH_SEP3: begin
                    if (dec == i_cfg.third_separator) begin
                        n_count = '0;
                        n_phase = PH_CHK;
                    end else begin
                        res.status = ST_NO_SEP3;
                        n_phase    = PH_WAIT;
                    end
                end
                PH_CHK: begin
                    if (!is_digit) begin
                        res.status = ST_BAD_CHK;
                        n_phase    = PH_WAIT;
                    end else begin
                        n_chk = {r_chk[11:0], nib};
                        if (last_digit(r_count, CHK_N)) begin
                            n_count = '0;
                            n_phase = PH_END;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
                PH_END: begin
                    n_phase = PH_WAIT;
                    if (dec == i_cfg.end_byte) begin
                        res.status            = ST_OK;
                        res.packet_done       = 1'b1;
                        res.sequence_value    = r_seq;
                        res.command_value     = r_cmd;
                        res.first_data_value  = r_d1;
                        res.second_data_value = r_d2;
                        res.checksum_value    = r_chk;
                    end else begin
                        res.status = ST_NO_END;
                    end
                end
                default: n_phase = PH_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_count <= '0;
            r_seq   <= '0;
            r_cmd   <= '0;
            r_d1    <= '0;
            r_d2    <= '0;
            r_chk   <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_seq   <= n_seq;
            r_cmd   <= n_cmd;
            r_d1    <= n_d1;
            r_d2    <= n_d2;
            r_chk   <= n_chk;
        end
    end

    assign o_result = res;

endmodule

// ===== design/hex_ascii_packet_deframer_core.sv =====
// Top level of the hex ASCII packet deframer: channels and result register.
// A result is valid in the cycle after its byte request is accepted. Throughput: one
// byte per cycle while the result register is empty or being read; the per-byte decode,
// compare and nibble shift sit between the parser state and the result register.
// Reset: synchronous, clears phase, digit count, accumulators and result
// valid, and loads the framing registers with their defaults.
module hex_ascii_packet_deframer_core #(
    parameter int SEQUENCE_DIGITS    = hapd_pkg::DEF_SEQUENCE_DIGITS,
    parameter int COMMAND_DIGITS     = hapd_pkg::DEF_COMMAND_DIGITS,
    parameter int FIRST_DATA_DIGITS  = hapd_pkg::DEF_FIRST_DATA_DIGITS,
    parameter int SECOND_DATA_DIGITS = hapd_pkg::DEF_SECOND_DATA_DIGITS,
    parameter int CHECKSUM_DIGITS    = hapd_pkg::DEF_CHECKSUM_DIGITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [hapd_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_rx_valid,
    output logic                       o_rx_ready,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [hapd_pkg::ST_W-1:0]  o_status,
    output logic                       o_packet_done,
    output logic [15:0]                o_sequence_value,
    output logic [7:0]                 o_command_value,
    output logic [31:0]                o_first_data_value,
    output logic [15:0]                o_second_data_value,
    output logic [15:0]                o_checksum_value
);
    import hapd_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result r_res;
    logic    r_out_valid;
    logic    take;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = !r_out_valid || i_res_ready;
    assign take        = i_rx_valid && o_rx_ready;

    hapd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    hapd_parser #(
        .SEQUENCE_DIGITS    (SEQUENCE_DIGITS),
        .COMMAND_DIGITS     (COMMAND_DIGITS),
        .FIRST_DATA_DIGITS  (FIRST_DATA_DIGITS),
        .SECOND_DATA_DIGITS (SECOND_DATA_DIGITS),
        .CHECKSUM_DIGITS    (CHECKSUM_DIGITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= res;
        end
    end

    assign o_res_valid         = r_out_valid;
    assign o_status            = r_res.status;
    assign o_packet_done       = r_res.packet_done;
    assign o_sequence_value    = r_res.sequence_value;
    assign o_command_value     = r_res.command_value;
    assign o_first_data_value  = r_res.first_data_value;
    assign o_second_data_value = r_res.second_data_value;
    assign o_checksum_value    = r_res.checksum_value;

endmodule

// ===== design/hapd_checker.sv =====
// Port-level checks of the deframer and their binding to the top level.
module hapd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_rx_ready,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [hapd_pkg::ST_W-1:0]  i_status,
    input logic                       i_packet_done,
    input logic [15:0]                i_sequence_value,
    input logic [7:0]                 i_command_value,
    input logic [31:0]                i_first_data_value,
    input logic [15:0]                i_second_data_value,
    input logic [15:0]                i_checksum_value
);
    import hapd_pkg::*;

    a_done_iff_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_packet_done == (i_status == ST_OK)))
        else $error("packet_done and ok status disagree");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_packet_done) |->
            (i_sequence_value == 16'h0) && (i_command_value == 8'h0) &&
            (i_first_data_value == 32'h0) && (i_second_data_value == 16'h0) &&
            (i_checksum_value == 16'h0))
        else $error("value fields not zero without packet_done");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_status <= ST_NO_END))
        else $error("status code out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_res_valid || i_res_ready) |-> i_rx_ready)
        else $error("byte request refused with result stage free");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_status) && $stable(i_packet_done)))
        else $error("stalled result changed");

endmodule

bind hex_ascii_packet_deframer_core hapd_checker u_hapd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rx_ready          (o_rx_ready),
    .i_res_valid         (o_res_valid),
    .i_res_ready         (i_res_ready),
    .i_status            (o_status),
    .i_packet_done       (o_packet_done),
    .i_sequence_value    (o_sequence_value),
    .i_command_value     (o_command_value),
    .i_first_data_value  (o_first_data_value),
    .i_second_data_value (o_second_data_value),
    .i_checksum_value    (o_checksum_value)
);

// ===== tb/sv/hapd_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the deframer: tracks framing registers, predicts and compares each result.
module hapd_result_checker
    import hapd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_rx_valid,
    input  logic             i_rx_ready,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  t_result          i_result,
    output int               o_mismatches,
    output int               o_outstanding
);

    t_cfg             framing;
    logic [PH_W-1:0]  cur_phase;
    logic [CNT_W-1:0] digit_cnt;
    logic [15:0]      seq_acc;
    logic [7:0]       cmd_acc;
    logic [31:0]      d1_acc;
    logic [15:0]      d2_acc;
    logic [15:0]      chk_acc;
    t_result          outcomes [$];
    int               mismatches = 0;

    assign o_mismatches = mismatches;

    initial o_outstanding = 0;

    function automatic void clear_fields();
        digit_cnt = '0;
        seq_acc   = '0;
        cmd_acc   = '0;
        d1_acc    = '0;
        d2_acc    = '0;
        chk_acc   = '0;
    endfunction

    function automatic logic [7:0] nibble_of(input logic [7:0] raw);
        if (raw >= 8'h41 && raw <= 8'h46) begin
            return raw - UPPER_OFFSET;
        end
        if (raw >= 8'h30 && raw <= 8'h39) begin
            return raw - DIGIT_OFFSET;
        end
        return raw;
    endfunction

    function automatic logic [ST_W-1:0] take_nibble(input logic [7:0] d, input int ndigits,
                                                    input logic [PH_W-1:0] next_ph,
                                                    input logic [ST_W-1:0] err);
        if (d > NIBBLE_MAX) begin
            cur_phase = PH_WAIT;
            return err;
        end
        if (int'(digit_cnt) + 1 == ndigits) begin
            digit_cnt = '0;
            cur_phase = next_ph;
        end else begin
            digit_cnt = digit_cnt + 1'b1;
        end
        return ST_NONE;
    endfunction

    function automatic logic [ST_W-1:0] take_separator(input logic [7:0] d, input logic [7:0] sep,
                                                       input logic [PH_W-1:0] next_ph,
                                                       input logic [ST_W-1:0] err);
        if (d == sep) begin
            digit_cnt = '0;
            cur_phase = next_ph;
            return ST_NONE;
        end
        cur_phase = PH_WAIT;
        return err;
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] raw);
        logic [7:0] d;
        t_result    r;
        d = nibble_of(raw);
        r = '0;
        if (d == framing.start_byte) begin
            clear_fields();
            cur_phase = PH_SEQ;
        end else begin
            case (cur_phase)
                PH_SEQ: begin
                    r.status = take_nibble(d, DEF_SEQUENCE_DIGITS, PH_SEP1, ST_BAD_SEQ);
                    if (r.status == ST_NONE) seq_acc = {seq_acc[11:0], d[3:0]};
                end
                PH_SEP1: r.status = take_separator(d, framing.first_separator, PH_CMD, ST_NO_SEP1);
                PH_CMD: begin
                    r.status = take_nibble(d, DEF_COMMAND_DIGITS, PH_SEP2, ST_BAD_CMD);
                    if (r.status == ST_NONE) cmd_acc = {cmd_acc[3:0], d[3:0]};
                end
                PH_SEP2: r.status = take_separator(d, framing.second_separator, PH_D1, ST_NO_SEP2);
                PH_D1: begin
                    r.status = take_nibble(d, DEF_FIRST_DATA_DIGITS, PH_D2, ST_BAD_D1);
                    if (r.status == ST_NONE) d1_acc = {d1_acc[27:0], d[3:0]};
                end
                PH_D2: begin
                    r.status = take_nibble(d, DEF_SECOND_DATA_DIGITS, PH_SEP3, ST_BAD_D2);
                    if (r.status == ST_NONE) d2_acc = {d2_acc[11:0], d[3:0]};
                end
                PH_SEP3: r.status = take_separator(d, framing.third_separator, PH_CHK, ST_NO_SEP3);
                PH_CHK: begin
                    r.status = take_nibble(d, DEF_CHECKSUM_DIGITS, PH_END, ST_BAD_CHK);
                    if (r.status == ST_NONE) chk_acc = {chk_acc[11:0], d[3:0]};
                end
                PH_END: begin
                    if (d == framing.end_byte) begin
                        r.status            = ST_OK;
                        r.packet_done       = 1'b1;
                        r.sequence_value    = seq_acc;
                        r.command_value     = cmd_acc;
                        r.first_data_value  = d1_acc;
                        r.second_data_value = d2_acc;
                        r.checksum_value    = chk_acc;
                    end else begin
                        r.status = ST_NO_END;
                    end
                    cur_phase = PH_WAIT;
                end
                default: cur_phase = PH_WAIT;
            endcase
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            framing   = '{RST_START_BYTE, RST_SEPARATOR, RST_SEPARATOR, RST_SEPARATOR,
                          RST_END_BYTE};
            cur_phase = PH_WAIT;
            clear_fields();
            outcomes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_START_BYTE: framing.start_byte       = i_cfg_data;
                    REG_FIRST_SEP:  framing.first_separator  = i_cfg_data;
                    REG_SECOND_SEP: framing.second_separator = i_cfg_data;
                    REG_THIRD_SEP:  framing.third_separator  = i_cfg_data;
                    REG_END_BYTE:   framing.end_byte         = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (outcomes.size() == 0) begin
                    $display("%0t: status expected none pending actual %0h", $time,
                             i_result.status);
                    mismatches++;
                end else begin
                    want = outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(i_result.status));
                    check_field("packet_done", 32'(want.packet_done), 32'(i_result.packet_done));
                    check_field("sequence", 32'(want.sequence_value),
                                32'(i_result.sequence_value));
                    check_field("command", 32'(want.command_value), 32'(i_result.command_value));
                    check_field("data1", want.first_data_value, i_result.first_data_value);
                    check_field("data2", 32'(want.second_data_value),
                                32'(i_result.second_data_value));
                    check_field("checksum", 32'(want.checksum_value),
                                32'(i_result.checksum_value));
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                outcomes.push_back(deframe_byte(i_rx_byte));
            end
        end
        o_outstanding <= outcomes.size();
    end

endmodule

// ===== tb/sv/hex_ascii_packet_deframer_core_test.sv =====
`timescale 1ns / 100ps
// Top of the deframer test: clock, reset, framed byte stimulus, stalls and verdict.
module hex_ascii_packet_deframer_core_test
    import hapd_pkg::*;
;

    localparam int RESET_CYCLES    = 2;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int TAIL_CYCLES     = 4;

    localparam int POS_SEP1  = 1 + DEF_SEQUENCE_DIGITS;
    localparam int POS_SEP2  = POS_SEP1 + 1 + DEF_COMMAND_DIGITS;
    localparam int POS_SEP3  = POS_SEP2 + 1 + DEF_FIRST_DATA_DIGITS + DEF_SECOND_DATA_DIGITS;
    localparam int POS_END   = POS_SEP3 + 1 + DEF_CHECKSUM_DIGITS;
    localparam int FRAME_LEN = POS_END + 1;

    localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = REG_END_BYTE + 1'b1;
    localparam logic [IDX_W-1:0] REG_INDEX_MAX    = '1;

    localparam int OPENING_LEN = 35;
    localparam logic [7:0] OPENING [0:OPENING_LEN-1] = '{
        8'hFF, 8'h00,
        8'h02, 8'h30, 8'h39, 8'h41, 8'h46, 8'h3A, 8'h0F, 8'h00, 8'h3A,
        8'h46, 8'h46, 8'h46, 8'h46, 8'h30, 8'h30, 8'h30, 8'h30,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h3A, 8'h43, 8'h44, 8'h45, 8'h46, 8'h03,
        8'h02, 8'h47,
        8'h02, 8'h31, 8'h02, 8'h5A
    };

    typedef enum int {RCV_OPEN, RCV_COIN, RCV_SPARSE, RCV_BLOCKED} t_rcv_mode;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [7:0]       cfg_data  = '0;
    logic             rx_valid  = 1'b0;
    logic [7:0]       rx_byte   = '0;
    logic             res_ready = 1'b0;

    logic             cfg_ready;
    logic             rx_ready;
    logic             res_valid;
    logic [ST_W-1:0]  res_status;
    logic             res_done;
    logic [15:0]      res_sequence;
    logic [7:0]       res_command;
    logic [31:0]      res_data1;
    logic [15:0]      res_data2;
    logic [15:0]      res_checksum;
    t_result          res_fields;

    int               mismatches;
    int               outstanding;
    int               cycle_count = 0;
    int               sent        = 0;
    int               burst_left  = 0;
    int               rcv_tick    = 0;
    t_rcv_mode        rcv_mode    = RCV_OPEN;
    logic [7:0]       cfg_val [0:4] = '{RST_START_BYTE, RST_SEPARATOR, RST_SEPARATOR,
                                        RST_SEPARATOR, RST_END_BYTE};

    assign res_fields = {res_status, res_done, res_sequence, res_command, res_data1, res_data2,
                         res_checksum};

    hex_ascii_packet_deframer_core dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_rx_valid          (rx_valid),
        .o_rx_ready          (rx_ready),
        .i_rx_byte           (rx_byte),
        .o_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .o_status            (res_status),
        .o_packet_done       (res_done),
        .o_sequence_value    (res_sequence),
        .o_command_value     (res_command),
        .o_first_data_value  (res_data1),
        .o_second_data_value (res_data2),
        .o_checksum_value    (res_checksum)
    );

    hapd_result_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_rx_valid    (rx_valid),
        .i_rx_ready    (rx_ready),
        .i_rx_byte     (rx_byte),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_result      (res_fields),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hold the result side on a ready pattern picked at random from four modes
    always @(negedge clk) begin
        if (rcv_tick % 64 == 0) rcv_mode = t_rcv_mode'($urandom_range(0, 3));
        case (rcv_mode)
            RCV_OPEN:   res_ready <= 1'b1;
            RCV_COIN:   res_ready <= 1'($urandom_range(0, 1));
            RCV_SPARSE: res_ready <= (rcv_tick % 5 == 0);
            default:    res_ready <= (rcv_tick % 16 >= 12);
        endcase
        rcv_tick++;
    end

    function automatic logic [7:0] encode_value(input logic [7:0] v);
        if (v <= 8'd9 && $urandom_range(0, 1) == 1) return v + DIGIT_OFFSET;
        if (v >= 8'd10 && v <= NIBBLE_MAX && $urandom_range(0, 1) == 1) return v + UPPER_OFFSET;
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        burst_left--;
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        rx_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= REG_END_BYTE) cfg_val[idx] = val;
        @(negedge clk);
    endtask

    task automatic send_packet(input bit broken);
        logic [7:0] frame [0:FRAME_LEN-1];
        logic [7:0] nib;
        int         len;
        int         cut;
        for (int k = 0; k < FRAME_LEN; k++) begin
            case (k)
                0:        frame[k] = encode_value(cfg_val[REG_START_BYTE]);
                POS_SEP1: frame[k] = encode_value(cfg_val[REG_FIRST_SEP]);
                POS_SEP2: frame[k] = encode_value(cfg_val[REG_SECOND_SEP]);
                POS_SEP3: frame[k] = encode_value(cfg_val[REG_THIRD_SEP]);
                POS_END:  frame[k] = encode_value(cfg_val[REG_END_BYTE]);
                default: begin
                    do nib = 8'($urandom_range(0, 15)); while (nib == cfg_val[REG_START_BYTE]);
                    frame[k] = encode_value(nib);
                end
            endcase
        end
        len = FRAME_LEN;
        if (broken) begin
            cut = $urandom_range(1, POS_END);
            if (cut == POS_SEP1 || cut == POS_SEP2 || cut == POS_SEP3 || cut == POS_END) begin
                frame[cut] = 8'($urandom_range(0, 255));
            end else begin
                frame[cut] = 8'($urandom_range(16, 255));
            end
            len = cut + 1;
        end
        for (int k = 0; k < len; k++) send_byte(frame[k]);
    endtask

    initial begin
        logic [7:0] new_cfg [0:4];
        int         quota;
        int         choice;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int k = 0; k < OPENING_LEN; k++) send_byte(OPENING[k]);
        for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
            if (phase_no != 0) begin
                wait_all_results();
                for (int k = 0; k <= int'(REG_END_BYTE); k++) begin
                    case (phase_no)
                        1: new_cfg[k] = (k == int'(REG_START_BYTE)) ? 8'hFF : 8'h00;
                        2: new_cfg[k] = (k == int'(REG_START_BYTE)) ? 8'h00 : 8'hFF;
                        default: begin
                            new_cfg[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                                                     : 8'($urandom_range(0, 255));
                            // pull most undecodable values back into reach
                            if (((new_cfg[k] >= 8'h30 && new_cfg[k] <= 8'h39) ||
                                 (new_cfg[k] >= 8'h41 && new_cfg[k] <= 8'h46)) &&
                                $urandom_range(0, 3) != 0) begin
                                new_cfg[k] = 8'($urandom_range(0, 15));
                            end
                        end
                    endcase
                    write_reg(IDX_W'(k), new_cfg[k]);
                end
                if (phase_no == 2) begin
                    for (int k = int'(REG_UNUSED_FIRST); k <= int'(REG_INDEX_MAX); k++) begin
                        write_reg(IDX_W'(k), 8'($urandom_range(0, 255)));
                    end
                end
                cfg_valid <= 1'b0;
            end
            quota = sent + ITEMS_PER_PHASE;
            while (sent < quota) begin
                choice = $urandom_range(0, 9);
                if (choice < 6) begin
                    send_packet(1'b0);
                end else if (choice < 8) begin
                    send_packet(1'b1);
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 24) == 0) wait_all_results();
            end
        end
        wait_all_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
